/* rtl/fwmf_pkg.sv */
`timescale 1ns / 1ps
package fwmf_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int INDEX_W   = 4;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  // Requests: op, value, index packed from bit 0 and padded to whole bytes.
  localparam int S_FIELDS_W = OP_W + DATA_W + INDEX_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  // Results: data, status, count packed from bit 0 and padded to whole bytes.
  localparam int M_FIELDS_W = DATA_W + STATUS_W + COUNT_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  localparam logic [DATA_W-1:0] ERR_DATA = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ      = 3'd0,
    OP_DEQ      = 3'd1,
    OP_PEEK     = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_MIN      = 3'd4,
    OP_READ_IDX = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;      // latch the accepted request
    logic    enq_write;    // append the latched value at the tail
    logic    deq_pop;      // advance head, drop one entry
    logic    clear;        // empty the queue
    logic    rd_head;      // read the head entry
    logic    rd_index;     // read the entry at the latched index
    logic    res_set;      // load result with a fixed data and status
    logic    res_err;      // with res_set: data is all ones, else zero
    status_t res_status;   // with res_set: status code
    logic    res_take_rd;  // load result with the read data, status ok
    logic    scan_start;   // restart the minimum scan at the head
    logic    scan_step;    // read the next entry of the scan
    logic    shift_init;   // start the shift at the minimum's position
    logic    shift_rd;     // read the entry in front of the shift position
    logic    shift_wr;     // store it one place back, step toward the head
    logic    put_min;      // store the minimum at the head
    logic    out_load;     // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic idx_oor;
    logic scan_last;
    logic best_at_head;
    logic shift_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/fwmf_ctrl.sv */
`timescale 1ns / 1ps
module fwmf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  fwmf_pkg::sts_t  sts,
  output fwmf_pkg::cmd_t  cmd
);
  import fwmf_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_EXEC     = 10'b00_0000_0010,
    S_WAIT_RD  = 10'b00_0000_0100,
    S_SCAN     = 10'b00_0000_1000,
    S_SCAN_END = 10'b00_0001_0000,
    S_DECIDE   = 10'b00_0010_0000,
    S_SHIFT_RD = 10'b00_0100_0000,
    S_SHIFT_WR = 10'b00_1000_0000,
    S_PUT_MIN  = 10'b01_0000_0000,
    S_FINISH   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        cmd.load_in = accept;
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FINISH;
        unique case (sts.op) inside
          OP_ENQ: begin
            cmd.res_set = 1'b1;
            if (sts.full) begin
              cmd.res_err    = 1'b1;
              cmd.res_status = ST_FULL;
            end else begin
              cmd.enq_write = 1'b1;
            end
          end
          OP_DEQ, OP_PEEK: begin
            if (sts.empty) begin
              cmd.res_set    = 1'b1;
              cmd.res_err    = 1'b1;
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.rd_head = 1'b1;
              state_next  = S_WAIT_RD;
            end
          end
          OP_CLEAR: begin
            cmd.clear   = 1'b1;
            cmd.res_set = 1'b1;
          end
          OP_MIN: begin
            cmd.res_set = 1'b1;
            if (!sts.empty) begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          OP_READ_IDX: begin
            if (sts.idx_oor) begin
              cmd.res_set    = 1'b1;
              cmd.res_err    = 1'b1;
              cmd.res_status = ST_RANGE;
            end else begin
              cmd.rd_index = 1'b1;
              state_next   = S_WAIT_RD;
            end
          end
          default: begin
            cmd.res_set = 1'b1;
          end
        endcase
      end
      S_WAIT_RD: begin
        cmd.res_take_rd = 1'b1;
        cmd.deq_pop     = (sts.op == OP_DEQ);
        state_next      = S_FINISH;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.best_at_head) begin
          state_next = S_FINISH;
        end else begin
          cmd.shift_init = 1'b1;
          state_next     = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd.shift_rd = 1'b1;
        state_next   = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = sts.shift_last ? S_PUT_MIN : S_SHIFT_RD;
      end
      S_PUT_MIN: begin
        cmd.put_min = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted request did not move to execute");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !sts.scan_last) |=> state == S_SCAN)
    else $error("scan ended early");

endmodule

/* rtl/fwmf_dp.sv */
`timescale 1ns / 1ps
module fwmf_dp #(
  parameter int DEPTH = fwmf_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [fwmf_pkg::OP_W-1:0]         in_op,
  input  logic [fwmf_pkg::DATA_W-1:0]       in_value,
  input  logic [fwmf_pkg::INDEX_W-1:0]      in_index,
  input  fwmf_pkg::cmd_t                    cmd,
  output fwmf_pkg::sts_t                    sts,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [fwmf_pkg::DATA_W-1:0]       out_data,
  output logic [fwmf_pkg::STATUS_W-1:0]     out_status,
  output logic [fwmf_pkg::COUNT_W-1:0]      out_count
);
  import fwmf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

  // Position of an entry counted from the head, wrapped into the buffer.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] hd,
                                         input logic [AW-1:0] rel);
    logic [AW:0] sum;
    sum = {1'b0, hd} + {1'b0, rel};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [DATA_W-1:0]  mem [DEPTH];
  logic [DATA_W-1:0]  rdata;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [DATA_W-1:0]  wr_data;

  logic [AW-1:0]      head;
  logic [CW-1:0]      occ;

  op_t                op_q;
  logic [DATA_W-1:0]  value_q;
  logic [INDEX_W-1:0] index_q;

  logic [AW-1:0]      scan_pos;
  logic               cmp_vld;
  logic [AW-1:0]      cmp_pos;
  logic signed [DATA_W-1:0] best_val;
  logic [AW-1:0]      best_pos;
  logic [AW-1:0]      shift_pos;

  logic [DATA_W-1:0]  res_data;
  status_t            res_status;

  // Single read port and single write port on the entry store.
  always_comb begin
    rd_addr = head;
    if (cmd.rd_head) begin
      rd_addr = head;
    end else if (cmd.rd_index) begin
      rd_addr = slot(head, AW'(index_q));
    end else if (cmd.scan_step) begin
      rd_addr = slot(head, scan_pos);
    end else if (cmd.shift_rd) begin
      rd_addr = slot(head, shift_pos - AW'(1));
    end
  end

  always_comb begin
    wr_en   = cmd.enq_write || cmd.shift_wr || cmd.put_min;
    wr_addr = head;
    wr_data = best_val;
    if (cmd.enq_write) begin
      wr_addr = slot(head, AW'(occ));
      wr_data = value_q;
    end else if (cmd.shift_wr) begin
      wr_addr = slot(head, shift_pos);
      wr_data = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q    <= op_t'(in_op);
      value_q <= in_value;
      index_q <= in_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occ  <= '0;
    end else if (cmd.clear) begin
      head <= '0;
      occ  <= '0;
    end else if (cmd.enq_write) begin
      occ <= occ + CW'(1);
    end else if (cmd.deq_pop) begin
      head <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
      occ  <= occ - CW'(1);
    end
  end

  // Minimum scan: reads issue one per cycle, and each compare follows in the cycle after its read.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_pos <= '0;
    end else if (cmd.scan_step) begin
      scan_pos <= scan_pos + AW'(1);
    end
    if (cmd.scan_step) begin
      cmp_pos <= scan_pos;
    end
    if (cmp_vld && (cmp_pos == '0 || $signed(rdata) < best_val)) begin
      best_val <= $signed(rdata);
      best_pos <= cmp_pos;
    end
    if (cmd.shift_init) begin
      shift_pos <= best_pos;
    end else if (cmd.shift_wr) begin
      shift_pos <= shift_pos - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_data   <= cmd.res_err ? ERR_DATA : '0;
      res_status <= cmd.res_status;
    end else if (cmd.res_take_rd) begin
      res_data   <= rdata;
      res_status <= ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data   <= res_data;
      out_status <= res_status;
      out_count  <= COUNT_W'(occ);
    end
  end

  always_comb begin
    sts.op           = op_q;
    sts.empty        = (occ == '0);
    sts.full         = (occ >= CW'(DEPTH));
    sts.idx_oor      = (XW'(index_q) >= XW'(occ));
    sts.scan_last    = ((CW'(scan_pos) + CW'(1)) == occ);
    sts.best_at_head = (best_pos == '0);
    sts.shift_last   = (shift_pos == AW'(1));
    sts.out_free     = !m_tvalid || m_tready;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(DEPTH))
    else $error("occupancy beyond depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head < AW'(DEPTH - 1) || head == AW'(DEPTH - 1))
    else $error("head beyond depth");

  a_enq_room: assert property (@(posedge clk) disable iff (rst)
    cmd.enq_write |-> occ < CW'(DEPTH))
    else $error("write into a full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.deq_pop |-> occ != '0)
    else $error("pop from an empty queue");

endmodule

/* rtl/fifo_with_min_to_front.sv */
`timescale 1ns / 1ps
// Channel   Direction  Signals                      Carries
// s_*       in         s_tvalid s_tready s_tdata    one request: an operation on the queue
// m_*       out        m_tvalid m_tready m_tdata    one result per request
//
// Enqueue, clear, unused codes, min to front on an empty queue and every error go
// from execute straight to the result. Dequeue, peek and read at index add the
// registered memory read. Min to front walks one memory read port over the N entries
// held; a minimum already at the head is left there, else from its position P each
// shift step reads and writes one entry and the minimum is stored at the head. Reset
// (rst, synchronous) empties the queue; no clearing pass is needed. A finished result
// waits in the output register while the next request is accepted; only the loading
// of that next result stalls on m_tready.
module fifo_with_min_to_front #(
  parameter int DEPTH = fwmf_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata from bit 0: op [2:0], value [34:3], index [38:35], zero pad [39]
  input  logic [fwmf_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata from bit 0: data [31:0], status [33:32], count [38:34], zero pad [39]
  output logic [fwmf_pkg::M_TDATA_W-1:0] m_tdata
);
  import fwmf_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [DATA_W-1:0]   out_data;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;

  // The controller sequences each request; the datapath holds the entry store,
  // head and occupancy, the scan registers, and the result registers.
  fwmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fwmf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_op      (s_tdata[OP_W-1:0]),
    .in_value   (s_tdata[OP_W+DATA_W-1:OP_W]),
    .in_index   (s_tdata[S_FIELDS_W-1:OP_W+DATA_W]),
    .cmd        (cmd),
    .sts        (sts),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .out_data   (out_data),
    .out_status (out_status),
    .out_count  (out_count)
  );

  // Result fields packed from the low bit, upper pad bits held at zero.
  assign m_tdata = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, out_count, out_status, out_data};

endmodule
